### rtl/core/bpht_pkg.sv
package bpht_pkg;

	// Number of keys in the scan; key bits above this count are ignored.
	localparam int KEY_COUNT = 8;

	// Fixed field widths of the scan and the tick.
	localparam int KEYS_W = 8;
	localparam int TICK_W = 32;
	localparam int CODE_W = 3;

	// Mask of the key bits that take part in tracking.
	localparam logic [KEYS_W-1:0] KEY_MASK =
		(KEY_COUNT >= KEYS_W) ? {KEYS_W{1'b1}} : KEYS_W'((64'd1 << KEY_COUNT) - 64'd1);

	// Hold time after reset, in milliseconds.
	localparam logic [TICK_W-1:0] HOLD_TIME_RESET = TICK_W'(2000);

	// Phase codes as they appear on the result word.
	localparam logic [CODE_W-1:0] PH_NONE     = 3'd0;
	localparam logic [CODE_W-1:0] PH_PRESSED  = 3'd1;
	localparam logic [CODE_W-1:0] PH_TIMING   = 3'd2;
	localparam logic [CODE_W-1:0] PH_HOLD     = 3'd3;
	localparam logic [CODE_W-1:0] PH_RELEASED = 3'd4;

	// Internal phase register, one-hot.
	typedef enum logic [4:0] {
		ST_NONE     = 5'b00001,
		ST_PRESSED  = 5'b00010,
		ST_TIMING   = 5'b00100,
		ST_HOLD     = 5'b01000,
		ST_RELEASED = 5'b10000
	} phase_t;

	// One result word.
	typedef struct packed {
		logic [CODE_W-1:0] phase;
		logic [KEYS_W-1:0] pressed;
		logic [KEYS_W-1:0] last;
	} result_t;

	// Map the one-hot phase onto its output code.
	function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
		logic [CODE_W-1:0] code;
		case (ph)
			ST_NONE:     code = PH_NONE;
			ST_PRESSED:  code = PH_PRESSED;
			ST_TIMING:   code = PH_TIMING;
			ST_HOLD:     code = PH_HOLD;
			ST_RELEASED: code = PH_RELEASED;
			default:     code = PH_NONE;
		endcase
		return code;
	endfunction

endpackage

### rtl/core/bpht_fsm.sv
module bpht_fsm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step_en,
	input  logic [bpht_pkg::KEYS_W-1:0]      scan_keys,
	input  logic [bpht_pkg::TICK_W-1:0]      scan_ms,
	input  logic                             cfg_wr_en,
	input  logic [bpht_pkg::TICK_W-1:0]      cfg_wr_data,
	output bpht_pkg::result_t                res
);
	import bpht_pkg::*;

	phase_t              phase_q, phase_d;
	logic [KEYS_W-1:0]   held_q, held_d;
	logic [KEYS_W-1:0]   released_q, released_d;
	logic [TICK_W-1:0]   start_q;
	logic                start_load;
	logic [TICK_W-1:0]   hold_time_q;
	logic [KEYS_W-1:0]   scan;
	logic [TICK_W-1:0]   elapsed;
	logic                hold_due;

	// Only the configured key bits are tracked.
	assign scan = scan_keys & KEY_MASK;

	// Wrapped time since timing started, checked against the hold time.
	assign elapsed  = scan_ms - start_q;
	assign hold_due = elapsed > hold_time_q;

	// Next phase and masks for the word in the input stage.
	always_comb begin
		phase_d    = phase_q;
		held_d     = held_q;
		released_d = released_q;
		start_load = 1'b0;
		case (phase_q)
			ST_NONE: begin
				if (scan != '0) begin
					phase_d = ST_PRESSED;
				end
				held_d = scan;
			end
			ST_PRESSED: begin
				if (scan == '0) begin
					phase_d = ST_RELEASED;
				end else if (scan == held_q) begin
					phase_d    = ST_TIMING;
					start_load = 1'b1;
				end else begin
					held_d = scan;
				end
			end
			ST_TIMING: begin
				if (scan == '0) begin
					phase_d = ST_RELEASED;
				end else if (scan == held_q) begin
					if (hold_due) begin
						phase_d = ST_HOLD;
					end
				end else begin
					held_d  = scan;
					phase_d = ST_PRESSED;
				end
			end
			ST_HOLD: begin
				if (scan == '0) begin
					phase_d = ST_RELEASED;
				end else if (scan != held_q) begin
					held_d  = scan;
					phase_d = ST_PRESSED;
				end
			end
			ST_RELEASED: begin
				released_d = held_q;
				held_d     = held_q ^ scan;
				phase_d    = ST_NONE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// The result word carries the state after this scan.
	assign res.phase   = phase_code(phase_d);
	assign res.pressed = held_d;
	assign res.last    = released_d;

	// Tracking state advances once per word leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ST_NONE;
			held_q     <= '0;
			released_q <= '0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			held_q     <= held_d;
			released_q <= released_d;
		end
	end

	// The start tick is only read in the timing phase, which loads it first.
	always_ff @(posedge clk) begin
		if (step_en && start_load) begin
			start_q <= scan_ms;
		end
	end

	// Hold time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= HOLD_TIME_RESET;
		end else if (cfg_wr_en) begin
			hold_time_q <= cfg_wr_data;
		end
	end

endmodule

### rtl/core/button_press_hold_tracker.sv
// Button press / hold / release tracker.
// Input channel: one word per key scan, scanned_keys (mask of keys down) and
// now_ms (free-running millisecond tick), with in_valid and in_stall.
// Output channel: one word per scan, event_phase (0 none, 1 pressed,
// 2 timing, 3 hold, 4 released), pressed_keys and last_keys, with out_valid
// and out_stall.
// Configuration: cfg_wr_en and cfg_wr_data write the hold time in
// milliseconds; write it only while no scan is in flight.
// The scan is registered in the input stage; its result word is registered in
// the output stage and shown there with out_valid until it is taken.
// Throughput is one scan per cycle while out_stall is low: an input register
// feeds the phase logic, whose result lands in an output register.
// Reset clears the phase to none, both masks to zero and the hold time to
// 2000 ms; both stages come up empty.
// When the receiver stalls, the output word holds; the input stage takes one
// more scan if empty, then raises in_stall until the output word moves on.
module button_press_hold_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bpht_pkg::KEYS_W-1:0]  scanned_keys,
	input  logic [bpht_pkg::TICK_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bpht_pkg::CODE_W-1:0]  event_phase,
	output logic [bpht_pkg::KEYS_W-1:0]  pressed_keys,
	output logic [bpht_pkg::KEYS_W-1:0]  last_keys,
	input  logic                         cfg_wr_en,
	input  logic [bpht_pkg::TICK_W-1:0]  cfg_wr_data
);
	import bpht_pkg::*;

	logic                valid_s1;
	logic [KEYS_W-1:0]   keys_s1;
	logic [TICK_W-1:0]   ms_s1;
	logic                valid_s2;
	result_t             res_s2;
	result_t             res;
	logic                out_free;
	logic                step_en;
	logic                in_take;

	// The output register can load when empty or when its word is taken.
	assign out_free = !valid_s2 || !out_stall;
	assign step_en  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			keys_s1 <= scanned_keys;
			ms_s1   <= now_ms;
		end
	end

	// Phase logic and tracking state.
	bpht_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.scan_keys   (keys_s1),
		.scan_ms     (ms_s1),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res         (res)
	);

	// Output stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign event_phase  = res_s2.phase;
	assign pressed_keys = res_s2.pressed;
	assign last_keys    = res_s2.last;

endmodule
